// ===== rtl/fpm3_pkg.sv =====
// ----------------------------------------------------------------------------
// fpm3_pkg
// Shared constants and controller/datapath types for the 3x3 fixed-point
// matrix multiplier.
// ----------------------------------------------------------------------------
package fpm3_pkg;

    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int DIM         = 3;
    localparam int ELEMS       = DIM * DIM;
    localparam int STORE_DEPTH = 2 * ELEMS;
    localparam int ADDR_W      = $clog2(ELEMS);
    localparam int IDX_W       = 4;
    localparam int CNT_W       = $clog2(STORE_DEPTH);
    localparam int DIM_W       = $clog2(DIM);

    typedef struct packed {
        logic              first;
        logic              last;
        logic [IDX_W-1:0]  idx;
    } tag_t;

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] waddr;
        logic              issue;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
        tag_t              tag;
    } cmd_t;

    typedef struct packed {
        logic idle;
    } status_t;

endpackage

// ===== rtl/fpm3_if.sv =====
// ----------------------------------------------------------------------------
// fpm3 stream interfaces
// Valid/ready channels for matrix elements in and result elements out.
// ----------------------------------------------------------------------------
interface fpm3_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [fpm3_pkg::WORD_W-1:0]  element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface fpm3_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fpm3_pkg::WORD_W-1:0]  product_value;
    logic        [fpm3_pkg::IDX_W-1:0]   product_index;
    logic                                last_result;

    modport source (output valid, output product_value, output product_index,
                    output last_result, input ready);
    modport sink   (input valid, input product_value, input product_index,
                    input last_result, output ready);
endinterface

// ===== rtl/fixed_point_matrix3x3_multiply.sv =====
// ----------------------------------------------------------------------------
// fixed_point_matrix3x3_multiply
// 3x3 fixed-point matrix multiply with approximate sign-magnitude products.
//
//   channel   dir  handshake     payload
//   operand   in   valid/ready   element_value (A row-major, then B)
//   result    out  valid/ready   product_value, product_index, last_result
//
// Loading accepts an element in every cycle that valid is high, 18 in all;
// ready drops during compute. Each result element is formed by three reads
// from the two operand RAMs, then a four-stage product and accumulate
// pipeline run one element at a time.
// Reset clears the sequencer and valids; operand RAM contents are left as is.
// A stalled result holds one element in the accumulator and one at the port.
// ----------------------------------------------------------------------------
module fixed_point_matrix3x3_multiply (
    input  logic              clk,
    input  logic              rst_n,
    fpm3_in_if.sink           operand,
    fpm3_out_if.source        result
);

    fpm3_pkg::cmd_t    cmd;
    fpm3_pkg::status_t status;

    fpm3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operand.valid),
        .in_ready (operand.ready),
        .status   (status),
        .cmd      (cmd)
    );

    fpm3_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wdata     (operand.element_value),
        .status    (status),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_value (result.product_value),
        .out_index (result.product_index),
        .out_last  (result.last_result)
    );

endmodule

// ===== rtl/fpm3_ram.sv =====
// ----------------------------------------------------------------------------
// fpm3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpm3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fpm3_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpm3_ctrl
// Load/compute sequencer: steers the 18 operand writes, then issues the
// 27 operand-pair reads one result element at a time.
// ----------------------------------------------------------------------------
module fpm3_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fpm3_pkg::status_t status,
    output fpm3_pkg::cmd_t    cmd
);

    localparam logic [0:0] ST_LOAD = 1'b0;
    localparam logic [0:0] ST_CALC = 1'b1;

    logic [0:0]                   state_reg, state_next;
    logic [fpm3_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [fpm3_pkg::DIM_W-1:0]   row_reg, row_next;
    logic [fpm3_pkg::DIM_W-1:0]   col_reg, col_next;
    logic [fpm3_pkg::DIM_W-1:0]   k_reg, k_next;
    logic [fpm3_pkg::CNT_W-1:0]   count_b;
    logic                         accept;
    logic                         in_a;
    logic                         k_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

    assign in_ready = (state_reg == ST_LOAD);
    assign accept   = in_valid && in_ready;
    assign in_a     = count_reg < fpm3_pkg::CNT_W'(fpm3_pkg::ELEMS);
    assign count_b  = count_reg - fpm3_pkg::CNT_W'(fpm3_pkg::ELEMS);
    assign k_last   = (k_reg == fpm3_pkg::DIM_W'(fpm3_pkg::DIM - 1));

    always_comb
    begin
        cmd         = '0;
        cmd.wr_a    = accept && in_a;
        cmd.wr_b    = accept && !in_a;
        cmd.waddr   = in_a ? count_reg[fpm3_pkg::ADDR_W-1:0]
                           : count_b[fpm3_pkg::ADDR_W-1:0];
        cmd.issue   = (state_reg == ST_CALC) && ((k_reg != '0) || status.idle);
        cmd.raddr_a = fpm3_pkg::ADDR_W'(fpm3_pkg::ADDR_W'(row_reg)
                      * fpm3_pkg::ADDR_W'(fpm3_pkg::DIM)) + fpm3_pkg::ADDR_W'(k_reg);
        cmd.raddr_b = fpm3_pkg::ADDR_W'(fpm3_pkg::ADDR_W'(k_reg)
                      * fpm3_pkg::ADDR_W'(fpm3_pkg::DIM)) + fpm3_pkg::ADDR_W'(col_reg);
        cmd.tag.first = (k_reg == '0);
        cmd.tag.last  = k_last;
        cmd.tag.idx   = fpm3_pkg::IDX_W'(fpm3_pkg::IDX_W'(row_reg)
                        * fpm3_pkg::IDX_W'(fpm3_pkg::DIM)) + fpm3_pkg::IDX_W'(col_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg == fpm3_pkg::CNT_W'(fpm3_pkg::STORE_DEPTH - 1))
                    begin
                        count_next = '0;
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_CALC:
            begin
                if (cmd.issue)
                begin
                    if (k_last)
                    begin
                        k_next = '0;
                        if (col_reg == fpm3_pkg::DIM_W'(fpm3_pkg::DIM - 1))
                        begin
                            col_next = '0;
                            if (row_reg == fpm3_pkg::DIM_W'(fpm3_pkg::DIM - 1))
                            begin
                                row_next   = '0;
                                state_next = ST_LOAD;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/fpm3_dp.sv =====
// ----------------------------------------------------------------------------
// fpm3_dp
// Operand stores, approximate sign-magnitude product pipeline, accumulator
// and output register.
// ----------------------------------------------------------------------------
module fpm3_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpm3_pkg::cmd_t                cmd,
    input  logic [fpm3_pkg::WORD_W-1:0]   wdata,
    output fpm3_pkg::status_t             status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fpm3_pkg::WORD_W-1:0]   out_value,
    output logic [fpm3_pkg::IDX_W-1:0]    out_index,
    output logic                          out_last
);

    localparam int W = fpm3_pkg::WORD_W;
    localparam int H = fpm3_pkg::HALF_W;

    logic [W-1:0]            a_rdata, b_rdata;
    logic [W-1:0]            ma_next, mb_next;

    logic                    s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    fpm3_pkg::tag_t          s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    logic [W-1:0]            ma_reg, mb_reg;
    logic                    s2_neg_reg, s3_neg_reg;
    logic [W-1:0]            hh_reg, hh_next;
    logic [H-1:0]            hl_reg, lh_reg;
    logic [W-1:0]            hl_next, lh_next;
    logic [W-1:0]            term_reg, term_next, raw_sum;
    logic [W-1:0]            acc_reg, acc_next;
    logic                    pend_v_reg;
    logic [fpm3_pkg::IDX_W-1:0] pend_idx_reg;
    logic                    out_v_reg;
    logic [W-1:0]            out_value_reg;
    logic [fpm3_pkg::IDX_W-1:0] out_index_reg;
    logic                    out_last_reg;
    logic                    move;

    fpm3_ram #(.WIDTH(W), .DEPTH(fpm3_pkg::ELEMS)) u_ram_a (
        .clk   (clk),
        .we    (cmd.wr_a),
        .waddr (cmd.waddr),
        .wdata (wdata),
        .raddr (cmd.raddr_a),
        .rdata (a_rdata)
    );

    fpm3_ram #(.WIDTH(W), .DEPTH(fpm3_pkg::ELEMS)) u_ram_b (
        .clk   (clk),
        .we    (cmd.wr_b),
        .waddr (cmd.waddr),
        .wdata (wdata),
        .raddr (cmd.raddr_b),
        .rdata (b_rdata)
    );

    assign ma_next   = a_rdata[W-1] ? (W'(0) - a_rdata) : a_rdata;
    assign mb_next   = b_rdata[W-1] ? (W'(0) - b_rdata) : b_rdata;
    assign hh_next   = W'(ma_reg[W-1:H]) * W'(mb_reg[W-1:H]);
    assign hl_next   = W'(ma_reg[W-1:H]) * W'(mb_reg[H-1:0]);
    assign lh_next   = W'(ma_reg[H-1:0]) * W'(mb_reg[W-1:H]);
    assign raw_sum   = hh_reg + W'(hl_reg) + W'(lh_reg);
    assign term_next = s3_neg_reg ? (W'(0) - raw_sum) : raw_sum;
    assign acc_next  = (s4_tag_reg.first ? W'(0) : acc_reg) + term_reg;
    assign move      = pend_v_reg && (!out_v_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            s4_v_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            if (s4_v_reg && s4_tag_reg.last)
            begin
                pend_v_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_v_reg <= 1'b0;
            end
            if (move)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= cmd.tag;
        s2_tag_reg <= s1_tag_reg;
        s3_tag_reg <= s2_tag_reg;
        s4_tag_reg <= s3_tag_reg;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        s2_neg_reg <= a_rdata[W-1] ^ b_rdata[W-1];
        hh_reg     <= hh_next;
        hl_reg     <= hl_next[W-1:H];
        lh_reg     <= lh_next[W-1:H];
        s3_neg_reg <= s2_neg_reg;
        term_reg   <= term_next;
        if (s4_v_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s4_v_reg && s4_tag_reg.last)
        begin
            pend_idx_reg <= s4_tag_reg.idx;
        end
        if (move)
        begin
            out_value_reg <= acc_reg;
            out_index_reg <= pend_idx_reg;
            out_last_reg  <= (pend_idx_reg == fpm3_pkg::IDX_W'(fpm3_pkg::ELEMS - 1));
        end
    end

    assign status.idle = !(s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg || pend_v_reg);
    assign out_valid   = out_v_reg;
    assign out_value   = out_value_reg;
    assign out_index   = out_index_reg;
    assign out_last    = out_last_reg;

endmodule

// ===== rtl/fpm3_checker.sv =====
// ----------------------------------------------------------------------------
// fpm3_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module fpm3_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [fpm3_pkg::WORD_W-1:0]   out_value,
    input logic [fpm3_pkg::IDX_W-1:0]    out_index,
    input logic                          out_last
);

    logic [fpm3_pkg::IDX_W-1:0] exp_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_idx_reg <= out_last ? '0 : exp_idx_reg + 1'b1;
        end
    end

    a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped during stall");

    a_stall_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_index))
        else $error("result changed during stall");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_index == exp_idx_reg)
        else $error("result element out of order");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_last == (out_index == fpm3_pkg::IDX_W'(fpm3_pkg::ELEMS - 1)))
        else $error("last marker mismatch");

endmodule

bind fixed_point_matrix3x3_multiply fpm3_checker u_fpm3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.product_value),
    .out_index (result.product_index),
    .out_last  (result.last_result)
);

// ===== tb/sv/fixed_point_matrix3x3_multiply_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_matrix3x3_multiply_tb
// Streams 18-element operand runs (left matrix, then right matrix) into the
// multiplier and checks every result element against a sign-magnitude
// approximate-product predictor. Both channels idle and stall at random, and
// the result side holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
typedef struct {
    logic [fpm3_pkg::WORD_W-1:0] value;
    logic [fpm3_pkg::IDX_W-1:0]  index;
    logic                        last;
} product_elem_t;

class matrix_product_scoreboard;
    logic [fpm3_pkg::WORD_W-1:0] operand_store [fpm3_pkg::STORE_DEPTH];
    int                          load_count;
    product_elem_t               expected_products [$];
    int                          mismatch_count;

    function new();
        load_count     = 0;
        mismatch_count = 0;
    endfunction

    function logic [fpm3_pkg::WORD_W-1:0] approx_product(logic [fpm3_pkg::WORD_W-1:0] a,
                                                         logic [fpm3_pkg::WORD_W-1:0] b);
        logic [fpm3_pkg::WORD_W-1:0] mag_a;
        logic [fpm3_pkg::WORD_W-1:0] mag_b;
        logic [fpm3_pkg::WORD_W-1:0] hi_hi;
        logic [fpm3_pkg::WORD_W-1:0] hi_lo;
        logic [fpm3_pkg::WORD_W-1:0] lo_hi;
        logic [fpm3_pkg::WORD_W-1:0] sum;
        mag_a = a[fpm3_pkg::WORD_W-1] ? (~a + 1'b1) : a;
        mag_b = b[fpm3_pkg::WORD_W-1] ? (~b + 1'b1) : b;
        hi_hi = mag_a[fpm3_pkg::WORD_W-1:fpm3_pkg::HALF_W]
                * mag_b[fpm3_pkg::WORD_W-1:fpm3_pkg::HALF_W];
        hi_lo = mag_a[fpm3_pkg::WORD_W-1:fpm3_pkg::HALF_W]
                * mag_b[fpm3_pkg::HALF_W-1:0];
        lo_hi = mag_a[fpm3_pkg::HALF_W-1:0]
                * mag_b[fpm3_pkg::WORD_W-1:fpm3_pkg::HALF_W];
        sum   = hi_hi + (hi_lo >> fpm3_pkg::HALF_W) + (lo_hi >> fpm3_pkg::HALF_W);
        return (a[fpm3_pkg::WORD_W-1] ^ b[fpm3_pkg::WORD_W-1]) ? (~sum + 1'b1) : sum;
    endfunction

    function void record_element(logic [fpm3_pkg::WORD_W-1:0] value);
        product_elem_t               elem;
        logic [fpm3_pkg::WORD_W-1:0] acc;
        operand_store[load_count] = value;
        load_count++;
        if (load_count == fpm3_pkg::STORE_DEPTH)
        begin
            load_count = 0;
            for (int row = 0; row < fpm3_pkg::DIM; row++)
            begin
                for (int col = 0; col < fpm3_pkg::DIM; col++)
                begin
                    acc = '0;
                    for (int k = 0; k < fpm3_pkg::DIM; k++)
                        acc += approx_product(
                            operand_store[row * fpm3_pkg::DIM + k],
                            operand_store[fpm3_pkg::ELEMS + k * fpm3_pkg::DIM + col]);
                    elem.value = acc;
                    elem.index = fpm3_pkg::IDX_W'(row * fpm3_pkg::DIM + col);
                    elem.last  = (row * fpm3_pkg::DIM + col == fpm3_pkg::ELEMS - 1);
                    expected_products.push_back(elem);
                end
            end
        end
    endfunction

    function void check_product(logic [fpm3_pkg::WORD_W-1:0] value,
                                logic [fpm3_pkg::IDX_W-1:0] index, logic last);
        product_elem_t elem;
        if (expected_products.size() == 0)
        begin
            $error("unexpected result transaction: product_value %h, product_index %0d",
                   value, index);
            mismatch_count++;
            return;
        end
        elem = expected_products.pop_front();
        if (value !== elem.value)
        begin
            $error("product_value: expected %h, actual %h", elem.value, value);
            mismatch_count++;
        end
        if (index !== elem.index)
        begin
            $error("product_index: expected %0d, actual %0d", elem.index, index);
            mismatch_count++;
        end
        if (last !== elem.last)
        begin
            $error("last_result: expected %b, actual %b", elem.last, last);
            mismatch_count++;
        end
    endfunction

    function int pending();
        return expected_products.size();
    endfunction
endclass

module fixed_point_matrix3x3_multiply_tb;

    localparam int RUN_COUNT      = 14;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int IDLE_LIMIT     = 3000;
    localparam int SETTLE_CYCLES  = 100;

    logic clk;
    logic rst_n;
    int   tx_max_gap;
    int   rx_max_stall;
    bit   holdoff_request;
    int   idle_cycles;

    matrix_product_scoreboard products = new();

    logic [fpm3_pkg::WORD_W-1:0] corner_elements [fpm3_pkg::STORE_DEPTH] = '{
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0000_0001, 32'h7FFF_0000, 32'hFFFF_0000,
        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
        32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
        32'h8000_0000, 32'h0001_0000, 32'h0000_FFFF
    };

    fpm3_in_if  operand_ch ();
    fpm3_out_if result_ch ();

    fixed_point_matrix3x3_multiply dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .result  (result_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [fpm3_pkg::WORD_W-1:0] random_element();
        logic [fpm3_pkg::WORD_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1:
            begin
                v = $urandom_range(0, 32'h0003_FFFF);
                if ($urandom_range(0, 1))
                    v = ~v + 1'b1;
            end
            2:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0000_0001;
                    default: v = 32'h0001_0000;
                endcase
            end
            3: v = $urandom | 32'h6000_0000;
            default:
            begin
                v = 32'h1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = ~v + 1'b1;
            end
        endcase
        return v;
    endfunction

    task automatic send_element(logic [fpm3_pkg::WORD_W-1:0] value, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            operand_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        operand_ch.valid         <= 1'b1;
        operand_ch.element_value <= value;
        do @(posedge clk); while (operand_ch.ready !== 1'b1);
        products.record_element(value);
    endtask

    task automatic send_random_run();
        for (int i = 0; i < fpm3_pkg::STORE_DEPTH; i++)
            send_element(random_element(), $urandom_range(0, tx_max_gap));
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        operand_ch.valid <= 1'b0;
        while (products.pending() != 0)
            @(posedge clk);
    endtask

    // result sink
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (holdoff_request)
            begin
                stall           = HOLDOFF_CYCLES;
                holdoff_request = 1'b0;
            end
            else
                stall = $urandom_range(0, rx_max_stall);
            if (stall > 0)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            products.check_product(result_ch.product_value, result_ch.product_index,
                                   result_ch.last_result);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                    = 1'b0;
        operand_ch.valid         = 1'b0;
        operand_ch.element_value = '0;
        result_ch.ready          = 1'b0;
        holdoff_request          = 1'b0;
        idle_cycles              = 0;
        tx_max_gap               = 15;
        rx_max_stall             = 15;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < fpm3_pkg::STORE_DEPTH; i++)
            send_element(corner_elements[i], $urandom_range(0, tx_max_gap));
        wait_results_drained();

        for (int run = 0; run < RUN_COUNT; run++)
        begin
            case (run)
                3:
                begin
                    tx_max_gap   = 0;
                    rx_max_stall = 0;
                end
                5:
                begin
                    tx_max_gap   = 15;
                    rx_max_stall = 15;
                end
                6:
                begin
                    // back up the block into its input
                    tx_max_gap      = 0;
                    holdoff_request = 1'b1;
                end
                8:
                begin
                    tx_max_gap = 15;
                    wait_results_drained();
                end
                10: tx_max_gap = 3;
                11:
                begin
                    tx_max_gap   = 15;
                    rx_max_stall = 2;
                end
                12: rx_max_stall = 15;
                default: ;
            endcase
            send_random_run();
        end
        @(negedge clk);
        operand_ch.valid <= 1'b0;

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (products.mismatch_count == 0 && products.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
